// ===== src/romaji_to_kana_key_converter_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the romaji to kana key converter
// Concurrent checks on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ROMAJI_TO_KANA_KEY_CONVERTER_UNIT_DEFINES_SVH
`define ROMAJI_TO_KANA_KEY_CONVERTER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define R2K_ASSERT_NOW(label, trig, cons_) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons_)) \
    else $error("r2k assertion failed");

// Next-cycle implication
`define R2K_ASSERT_NEXT(label, trig, cons_) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons_)) \
    else $error("r2k assertion failed");

`else

`define R2K_ASSERT_NOW(label, trig, cons_)
`define R2K_ASSERT_NEXT(label, trig, cons_)

`endif

`endif

// ===== src/r2k_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// r2k_pkg
// Types, constants and kana lookup tables for the romaji to kana converter.
// ---------------------------------------------------------------------------
package r2k_pkg;

  localparam logic [7:0]  KeyFirst   = 8'h04;
  localparam logic [7:0]  KeyLast    = 8'h1d;
  localparam logic [13:0] KanaN      = 14'h3093;
  localparam logic [4:0]  LetterN    = 5'd13;
  localparam logic [4:0]  LetterQ    = 5'd16;
  localparam logic [4:0]  HeldMax    = 5'd26;
  localparam logic [6:0]  AsciiN     = 7'h6e;
  localparam logic [6:0]  AsciiBase  = 7'h60;  // 'a' minus one, held is letter + 1
  localparam int          RowCount   = 14;
  localparam int          ColCount   = 5;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_CONS = 2'd1,
    PHASE_N    = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [4:0] held;
  } parse_state_t;

  typedef struct packed {
    logic        has_kana;
    logic [13:0] kana_code;
    logic [6:0]  pending_letter;
  } kana_result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] row;
  } row_sel_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] col;
  } vowel_sel_t;

  // rows k s t n h m y r w g z d b p, columns a i u e o; zero marks a hole
  localparam logic [13:0] KanaRows [RowCount][ColCount] = '{
    '{14'h304B, 14'h304D, 14'h304F, 14'h3051, 14'h3053},
    '{14'h3055, 14'h3057, 14'h3059, 14'h305B, 14'h305D},
    '{14'h305F, 14'h3061, 14'h3064, 14'h3066, 14'h3068},
    '{14'h306A, 14'h306B, 14'h306C, 14'h306D, 14'h306E},
    '{14'h306F, 14'h3072, 14'h3075, 14'h3078, 14'h307B},
    '{14'h307E, 14'h307F, 14'h3080, 14'h3081, 14'h3082},
    '{14'h3084, 14'h0000, 14'h3086, 14'h0000, 14'h3088},
    '{14'h3089, 14'h308A, 14'h308B, 14'h308C, 14'h308D},
    '{14'h308F, 14'h0000, 14'h0000, 14'h0000, 14'h3092},
    '{14'h304C, 14'h304E, 14'h3050, 14'h3052, 14'h3054},
    '{14'h3056, 14'h3058, 14'h305A, 14'h305C, 14'h305E},
    '{14'h3060, 14'h3062, 14'h3065, 14'h3067, 14'h3069},
    '{14'h3070, 14'h3073, 14'h3076, 14'h3079, 14'h307C},
    '{14'h3071, 14'h3074, 14'h3077, 14'h307A, 14'h307D}
  };

  localparam logic [13:0] VowelKana [ColCount] = '{
    14'h3042, 14'h3044, 14'h3046, 14'h3048, 14'h304A
  };

  function automatic row_sel_t letter_row(logic [4:0] letter);
    row_sel_t r;
    r.valid = 1'b1;
    case (letter)
      5'd1:    r.row = 4'd12;  // b
      5'd3:    r.row = 4'd11;  // d
      5'd6:    r.row = 4'd9;   // g
      5'd7:    r.row = 4'd4;   // h
      5'd10:   r.row = 4'd0;   // k
      5'd12:   r.row = 4'd5;   // m
      5'd13:   r.row = 4'd3;   // n
      5'd15:   r.row = 4'd13;  // p
      5'd17:   r.row = 4'd7;   // r
      5'd18:   r.row = 4'd1;   // s
      5'd19:   r.row = 4'd2;   // t
      5'd22:   r.row = 4'd8;   // w
      5'd24:   r.row = 4'd6;   // y
      5'd25:   r.row = 4'd10;  // z
      default: begin
        r.valid = 1'b0;
        r.row   = 4'd0;
      end
    endcase
    return r;
  endfunction

  function automatic vowel_sel_t letter_vowel(logic [4:0] letter);
    vowel_sel_t v;
    v.valid = 1'b1;
    case (letter)
      5'd0:    v.col = 3'd0;  // a
      5'd8:    v.col = 3'd1;  // i
      5'd20:   v.col = 3'd2;  // u
      5'd4:    v.col = 3'd3;  // e
      5'd14:   v.col = 3'd4;  // o
      default: begin
        v.valid = 1'b0;
        v.col   = 3'd0;
      end
    endcase
    return v;
  endfunction

  function automatic logic [13:0] pair_kana(logic [4:0] letter, logic [2:0] col);
    row_sel_t    r;
    logic [13:0] k;
    r = letter_row(letter);
    k = '0;
    if (r.valid && r.row < 4'(RowCount) && col < 3'(ColCount)) begin
      k = KanaRows[r.row][col];
    end
    return k;
  endfunction

  function automatic logic [13:0] vowel_kana(logic [2:0] col);
    logic [13:0] k;
    k = '0;
    if (col < 3'(ColCount)) begin
      k = VowelKana[col];
    end
    return k;
  endfunction

endpackage

// ===== src/r2k_key_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// r2k_key_if
// Keycode input channel: valid/ready with one HID usage code.
// ---------------------------------------------------------------------------
interface r2k_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] keycode;

  modport source (output valid, output keycode, input ready);
  modport sink   (input valid, input keycode, output ready);
endinterface

// ===== src/r2k_kana_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// r2k_kana_if
// Result channel: valid/ready with kana code point and pending letter.
// ---------------------------------------------------------------------------
interface r2k_kana_if;
  logic        valid;
  logic        ready;
  logic        has_kana;
  logic [13:0] kana_code;
  logic [6:0]  pending_letter;

  modport source (output valid, output has_kana, output kana_code,
                  output pending_letter, input ready);
  modport sink   (input valid, input has_kana, input kana_code,
                  input pending_letter, output ready);
endinterface

// ===== src/r2k_cfg_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// r2k_cfg_if
// Configuration write channel for the mode register.
// ---------------------------------------------------------------------------
interface r2k_cfg_if;
  logic valid;
  logic ready;
  logic romaji_mode;

  modport source (output valid, output romaji_mode, input ready);
  modport sink   (input valid, input romaji_mode, output ready);
endinterface

// ===== src/r2k_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// r2k_step
// One parser step: keycode and current parse state to next state and result.
// ---------------------------------------------------------------------------
module r2k_step (
  input  logic                 romaji_mode,
  input  logic [7:0]           keycode,
  input  r2k_pkg::parse_state_t cur,
  output r2k_pkg::parse_state_t nxt,
  output r2k_pkg::kana_result_t res
);

  logic                is_letter;
  logic [4:0]          letter;
  r2k_pkg::vowel_sel_t vsel;
  logic                is_cons;
  logic                held_ok;
  logic                nxt_held_ok;
  logic [13:0]         kana;

  assign is_letter = (keycode >= r2k_pkg::KeyFirst) && (keycode <= r2k_pkg::KeyLast);
  assign letter    = 5'(keycode - r2k_pkg::KeyFirst);
  assign vsel      = r2k_pkg::letter_vowel(letter);
  assign is_cons   = !vsel.valid && (letter != r2k_pkg::LetterQ);
  assign held_ok   = (cur.held != 5'd0) && (cur.held <= r2k_pkg::HeldMax);

  always_comb begin
    nxt  = cur;
    kana = '0;
    if (romaji_mode && is_letter) begin
      case (cur.phase)
        r2k_pkg::PHASE_CONS: begin
          if (vsel.valid) begin
            if (held_ok) begin
              kana = r2k_pkg::pair_kana(5'(cur.held - 5'd1), vsel.col);
            end
            nxt.phase = r2k_pkg::PHASE_IDLE;
            nxt.held  = 5'd0;
          end else if (letter == r2k_pkg::LetterN) begin
            nxt.phase = r2k_pkg::PHASE_N;  // held consonant kept
          end else if (is_cons) begin
            nxt.held = 5'(letter + 5'd1);
          end
        end
        r2k_pkg::PHASE_N: begin
          if (vsel.valid) begin
            kana      = r2k_pkg::pair_kana(r2k_pkg::LetterN, vsel.col);
            nxt.phase = r2k_pkg::PHASE_IDLE;
          end else if (is_cons) begin
            kana      = r2k_pkg::KanaN;
            nxt.phase = r2k_pkg::PHASE_CONS;
            nxt.held  = 5'(letter + 5'd1);
          end
        end
        default: begin
          // idle; the unused phase code behaves the same
          if (vsel.valid) begin
            kana      = r2k_pkg::vowel_kana(vsel.col);
            nxt.phase = r2k_pkg::PHASE_IDLE;
          end else if (letter == r2k_pkg::LetterN) begin
            nxt.phase = r2k_pkg::PHASE_N;
          end else if (is_cons) begin
            nxt.phase = r2k_pkg::PHASE_CONS;
            nxt.held  = 5'(letter + 5'd1);
          end
        end
      endcase
    end
  end

  assign nxt_held_ok = (nxt.held != 5'd0) && (nxt.held <= r2k_pkg::HeldMax);

  always_comb begin
    res.has_kana  = (kana != 14'd0);
    res.kana_code = kana;
    if (nxt.phase == r2k_pkg::PHASE_CONS && nxt_held_ok) begin
      res.pending_letter = 7'(r2k_pkg::AsciiBase + 7'(nxt.held));
    end else if (nxt.phase == r2k_pkg::PHASE_N) begin
      res.pending_letter = r2k_pkg::AsciiN;
    end else begin
      res.pending_letter = 7'd0;
    end
  end

endmodule

// ===== src/romaji_to_kana_key_converter_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// romaji_to_kana_key_converter_unit
// HID letter keys parsed as romaji into hiragana code points, one result
// per key.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                   transfer when
//  key      in   keycode[7:0]                              valid && ready
//  kana     out  has_kana, kana_code[13:0], pending[6:0]   valid && ready
//  cfg      in   romaji_mode                               valid && ready
//
//  One key per cycle sustained while kana.ready holds. A key waits in the
//  input register; the parser step and the result register then update
//  together once the result stage is free, which makes the result valid.
//  The parse state loop closes through that single step, so successive
//  keys see each other's state.
//  rst is synchronous and clears mode, parse state and both valids.
//  A stalled result holds; the input register still takes a key while the
//  result waits, and input ready drops only once both stages are full.
//  cfg is always ready; a mode write also clears the parse state.
// ---------------------------------------------------------------------------
`include "romaji_to_kana_key_converter_unit_defines.svh"

module romaji_to_kana_key_converter_unit (
  input  logic           clk,
  input  logic           rst,
  r2k_key_if.sink        key,
  r2k_kana_if.source     kana,
  r2k_cfg_if.sink        cfg
);

  logic                  romaji_mode;
  r2k_pkg::parse_state_t parse_state;
  r2k_pkg::parse_state_t parse_state_next;
  r2k_pkg::kana_result_t step_res;

  logic                  in_valid;
  logic [7:0]            in_keycode;
  logic                  out_valid;
  r2k_pkg::kana_result_t out_res;

  logic                  out_free;
  logic                  advance;
  logic                  key_fire;
  logic                  cfg_fire;

  assign out_free  = !out_valid || kana.ready;
  assign advance   = in_valid && out_free;
  assign key.ready = !in_valid || advance;
  assign key_fire  = key.valid && key.ready;
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;

  r2k_step u_step (
    .romaji_mode (romaji_mode),
    .keycode     (in_keycode),
    .cur         (parse_state),
    .nxt         (parse_state_next),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      out_valid         <= 1'b0;
      romaji_mode       <= 1'b0;
      parse_state.phase <= r2k_pkg::PHASE_IDLE;
      parse_state.held  <= 5'd0;
    end else begin
      if (key.ready) begin
        in_valid <= key.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (kana.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_fire) begin
        romaji_mode       <= cfg.romaji_mode;
        parse_state.phase <= r2k_pkg::PHASE_IDLE;
        parse_state.held  <= 5'd0;
      end else if (advance) begin
        parse_state <= parse_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_fire) begin
      in_keycode <= key.keycode;
    end
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign kana.valid          = out_valid;
  assign kana.has_kana       = out_res.has_kana;
  assign kana.kana_code      = out_res.kana_code;
  assign kana.pending_letter = out_res.pending_letter;

  `R2K_ASSERT_NOW(a_flag_matches_code, out_valid,
                  out_res.has_kana == (out_res.kana_code != 14'd0))
  `R2K_ASSERT_NOW(a_cons_has_held, parse_state.phase == r2k_pkg::PHASE_CONS,
                  parse_state.held != 5'd0)
  `R2K_ASSERT_NEXT(a_cfg_clears, cfg_fire,
                   parse_state.phase == r2k_pkg::PHASE_IDLE && parse_state.held == 5'd0)
  `R2K_ASSERT_NEXT(a_alpha_keeps_state, advance && !romaji_mode && !cfg_fire,
                   $stable(parse_state) && !out_res.has_kana)
  `R2K_ASSERT_NOW(a_pending_range, out_valid,
                  out_res.pending_letter == 7'd0 ||
                  (out_res.pending_letter >= 7'h61 && out_res.pending_letter <= 7'h7a))

endmodule
